// ===== hdl/bpp_pkg.sv =====
// Package for the buzzer pattern player: item kinds, payload structs, sizes.
// No dependencies; imported by bpp_engine and buzzer_pattern_player_core.
package bpp_pkg;

    localparam int PATTERN_DEPTH = 16;
    localparam int DURATION_BITS = 16;
    localparam int SLOT_BITS     = $clog2(PATTERN_DEPTH);
    localparam int LEN_BITS      = $clog2(PATTERN_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_PLAY  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  entry_index;
        logic [15:0] entry_duration;
        logic [4:0]  pattern_length;
        logic        repeat_request;
    } bpp_in_t;

    typedef struct packed {
        logic buzzer;
        logic playing;
    } bpp_out_t;

endpackage

// ===== hdl/bpp_engine.sv =====
// Pattern store and playback state; one item applied per accepted transfer.
// Depends on bpp_pkg.
module bpp_engine
    import bpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_en,
    input  bpp_in_t  item,
    output bpp_out_t result
);

    localparam logic [DURATION_BITS-1:0] DUR_MAX = {DURATION_BITS{1'b1}};
    localparam logic [LEN_BITS-1:0] DEPTH_LEN = LEN_BITS'(PATTERN_DEPTH);

    logic [DURATION_BITS-1:0] store_reg [PATTERN_DEPTH];

    logic [DURATION_BITS-1:0] remaining_reg, remaining_next;
    logic [LEN_BITS-1:0]      next_slot_reg, next_slot_next;
    logic [LEN_BITS-1:0]      length_reg, length_next;
    logic                     repeat_reg, repeat_next;
    logic                     buzzer_reg, buzzer_next;
    logic                     active_reg, active_next;

    logic [DURATION_BITS-1:0] first_dur;
    logic [DURATION_BITS-1:0] slot_dur;
    logic [DURATION_BITS-1:0] wr_dur;
    logic [LEN_BITS-1:0]      play_len;

    assign first_dur = store_reg[0];
    assign slot_dur  = store_reg[next_slot_reg[SLOT_BITS-1:0]];

    always_comb
    begin
        if (DURATION_BITS < 16 && (32'(item.entry_duration) > 32'(DUR_MAX)))
            wr_dur = DUR_MAX;
        else
            wr_dur = DURATION_BITS'(item.entry_duration);
        if (32'(item.pattern_length) > 32'(PATTERN_DEPTH))
            play_len = DEPTH_LEN;
        else
            play_len = LEN_BITS'(item.pattern_length);
    end

    always_ff @(posedge clk)
    begin
        if (item_en && item.kind == KIND_WRITE &&
            32'(item.entry_index) < 32'(PATTERN_DEPTH))
        begin
            store_reg[item.entry_index[SLOT_BITS-1:0]] <= wr_dur;
        end
    end

    always_comb
    begin
        remaining_next = remaining_reg;
        next_slot_next = next_slot_reg;
        length_next    = length_reg;
        repeat_next    = repeat_reg;
        buzzer_next    = buzzer_reg;
        active_next    = active_reg;
        if (item_en)
        begin
            case (item.kind)
                KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        if (remaining_reg > DURATION_BITS'(1))
                            remaining_next = remaining_reg - DURATION_BITS'(1);
                        else if (next_slot_reg < length_reg)
                        begin
                            buzzer_next    = ~buzzer_reg;
                            remaining_next = slot_dur;
                            next_slot_next = next_slot_reg + LEN_BITS'(1);
                        end
                        else if (repeat_reg)
                        begin
                            buzzer_next    = 1'b1;
                            remaining_next = first_dur;
                            next_slot_next = LEN_BITS'(1);
                        end
                        else
                        begin
                            buzzer_next    = 1'b0;
                            active_next    = 1'b0;
                            remaining_next = '0;
                        end
                    end
                end
                KIND_PLAY:
                begin
                    if (play_len == '0)
                    begin
                        buzzer_next    = 1'b0;
                        active_next    = 1'b0;
                        length_next    = '0;
                        next_slot_next = '0;
                        remaining_next = '0;
                        repeat_next    = 1'b0;
                    end
                    else
                    begin
                        length_next    = play_len;
                        repeat_next    = item.repeat_request;
                        buzzer_next    = 1'b1;
                        remaining_next = first_dur;
                        next_slot_next = LEN_BITS'(1);
                        active_next    = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            next_slot_reg <= '0;
            length_reg    <= '0;
            repeat_reg    <= 1'b0;
            buzzer_reg    <= 1'b0;
            active_reg    <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            next_slot_reg <= next_slot_next;
            length_reg    <= length_next;
            repeat_reg    <= repeat_next;
            buzzer_reg    <= buzzer_next;
            active_reg    <= active_next;
        end
    end

    assign result.buzzer  = buzzer_next;
    assign result.playing = active_next;

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> !buzzer_reg)
        else $error("buzzer on while idle");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (next_slot_reg != '0 && next_slot_reg <= length_reg))
        else $error("slot pointer outside active pattern");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= DEPTH_LEN)
        else $error("active length beyond depth");

    a_play_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_en && item.kind == KIND_PLAY && item.pattern_length != '0)
        |=> (active_reg && buzzer_reg && next_slot_reg == LEN_BITS'(1)))
        else $error("play command did not start pattern");

endmodule

// ===== hdl/buzzer_pattern_player_core.sv =====
// Top level of the buzzer pattern player: handshake and two-entry result queue.
// Depends on bpp_pkg and bpp_engine.
//
// Each input transfer (tick, entry write or play command) is applied to the
// pattern state in the cycle it is accepted and yields exactly one result,
// so the block takes one item per clock while a queue entry is free.
// Results leave through a two-entry queue; in_ready falls only while both
// entries wait on out_ready. A result reaches out_data the cycle after its
// item is accepted into an empty queue, else it waits behind older results.
// The sixteen-entry pattern store has no reset: slots must be written
// before a play command reaches them.
module buzzer_pattern_player_core
    import bpp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  bpp_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output bpp_out_t out_data
);

    bpp_out_t    fifo_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;
    bpp_out_t    result;

    assign in_ready  = (count_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = fifo_reg[rd_ptr_reg];

    bpp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_en (push),
        .item    (in_data),
        .result  (result)
    );

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count overflow");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg ^ rd_ptr_reg) == count_reg[0])
        else $error("queue pointers disagree with count");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> out_valid)
        else $error("accepted item produced no result");

endmodule
